FILE: design/dlaf_pkg.sv
`default_nettype none

package dlaf_pkg;

  // batch size and derived widths
  localparam int LOCKS_REQUIRED = 8;
  localparam int CNT_W  = $clog2(LOCKS_REQUIRED + 1);
  localparam int IDX_W  = (LOCKS_REQUIRED > 1) ? $clog2(LOCKS_REQUIRED) : 1;
  localparam int CSUM_W = 8 + CNT_W;
  localparam int FSUM_W = 16 + CNT_W;
  localparam int BLEND_W = 24;

  // rounded coarse sum and its fixed divisor
  localparam int CRND_W   = CSUM_W + 1;
  localparam int CAVG_DIV = 2 * LOCKS_REQUIRED;

  // shared divider widths: the blend numerator is the widest operand
  localparam int DIV_NUM_W = 25;
  localparam int DIV_DEN_W = 10;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] dividend;
    logic [DIV_DEN_W-1:0] divisor;
  } dlaf_div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quotient;
  } dlaf_div_rsp_t;

endpackage

`default_nettype wire

FILE: design/dll_lock_average_filter.sv
// Delay-line lock average filter.
// Input channel (in_valid/in_ready): one lock readback per item. Items that
// are not locked or arrive once the batch store is full leave no trace; a
// locked item stores its coarse code and a fine word built from the top
// byte and the two thermometer codes. Items that do not end a batch leave
// in_ready high. An item with in_last closes the batch: the block drops
// in_ready, walks the store twice with a coarse and a fine accumulator and
// uses one shared shift-subtract divider for up to two divides.
// Result channel (out_valid/out_ready): one item per batch carrying the
// rounded coarse average, the smoothed fine value, the number of entries
// stored and a no-match flag. The result sits in an output register, so new
// readbacks are taken while it waits; a second batch end holds in its last
// step until the earlier result has been taken.
// cfg_we/cfg_wdata write the previous-value weight of the blend (reset 1).
// Synchronous reset clears the batch and the smoothed history and sets the weight to 1.
`default_nettype none

module dll_lock_average_filter
  import dlaf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_locked,
  input  wire logic [15:0] in_fine_bank_therm,
  input  wire logic [15:0] in_fine_low_therm,
  input  wire logic [7:0]  in_fine_top_byte,
  input  wire logic [7:0]  in_coarse_code,
  input  wire logic        in_reinit,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_coarse_average,
  output logic [15:0]      out_fine_smoothed,
  output logic [3:0]       out_locks_taken,
  output logic             out_no_match,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CSUM  = 3'd1;
  localparam logic [2:0] S_CDIV  = 3'd2;
  localparam logic [2:0] S_FSUM  = 3'd3;
  localparam logic [2:0] S_FDIV  = 3'd4;
  localparam logic [2:0] S_BLEND = 3'd5;
  localparam logic [2:0] S_BDIV  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  // thermometer code to bank index; 16 means keep the previous bank
  function automatic logic [4:0] therm_idx(input logic [15:0] code);
    logic [4:0] idx;
    idx = '0;
    for (int k = 0; k < 16; k++) begin
      if (code[k]) idx = 5'(k + 1);
    end
    return idx;
  endfunction

  logic [2:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   match_r, match_nxt;
  logic [3:0]         bank_r, bank_nxt;
  logic [3:0]         low_bank_r, low_bank_nxt;
  logic [7:0]         prev_coarse_r, prev_coarse_nxt;
  logic [15:0]        prev_fine_r, prev_fine_nxt;
  logic [7:0]         weight_r, weight_nxt;
  logic               launched_r, launched_nxt;
  logic               reinit_r, reinit_nxt;
  logic [CSUM_W-1:0]  csum_r, csum_nxt;
  logic [FSUM_W-1:0]  fsum_r, fsum_nxt;
  logic [7:0]         cavg_r, cavg_nxt;
  logic [15:0]        favg_r, favg_nxt;
  logic [15:0]        fine_res_r, fine_res_nxt;
  logic [BLEND_W-1:0] num_r, num_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_cavg_r, out_cavg_nxt;
  logic [15:0]        out_fine_r, out_fine_nxt;
  logic [3:0]         out_locks_r, out_locks_nxt;
  logic               out_nm_r, out_nm_nxt;

  logic [7:0]  coarse_store_r [LOCKS_REQUIRED];
  logic [15:0] fine_store_r   [LOCKS_REQUIRED];

  logic          accept;
  logic          store_en;
  logic [4:0]    bank_idx, low_idx;
  logic [3:0]    bank_new, low_new;
  logic [7:0]    rd_coarse;
  logic [15:0]   rd_fine;
  logic [8:0]    weight_p1;
  logic [CRND_W-1:0] csum_rnd;
  dlaf_div_req_t div_req;
  dlaf_div_rsp_t div_rsp;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign store_en = accept && in_locked && (count_r < CNT_W'(LOCKS_REQUIRED));

  // bank indices of the incoming item
  assign bank_idx = therm_idx(in_fine_bank_therm);
  assign low_idx  = therm_idx(in_fine_low_therm);
  assign bank_new = bank_idx[4] ? bank_r : bank_idx[3:0];
  assign low_new  = low_idx[4] ? low_bank_r : low_idx[3:0];

  // store walk read port
  assign rd_coarse = coarse_store_r[idx_r[IDX_W-1:0]];
  assign rd_fine   = fine_store_r[idx_r[IDX_W-1:0]];
  assign weight_p1 = {1'b0, weight_r} + 9'd1;

  // coarse sum with the half-divisor added for rounding
  assign csum_rnd = {csum_r, 1'b0} + CRND_W'(LOCKS_REQUIRED);

  // sequencer and datapath
  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    idx_nxt         = idx_r;
    match_nxt       = match_r;
    bank_nxt        = bank_r;
    low_bank_nxt    = low_bank_r;
    prev_coarse_nxt = prev_coarse_r;
    prev_fine_nxt   = prev_fine_r;
    weight_nxt      = cfg_we ? cfg_wdata : weight_r;
    launched_nxt    = launched_r;
    reinit_nxt      = reinit_r;
    csum_nxt        = csum_r;
    fsum_nxt        = fsum_r;
    cavg_nxt        = cavg_r;
    favg_nxt        = favg_r;
    fine_res_nxt    = fine_res_r;
    num_nxt         = num_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_cavg_nxt    = out_cavg_r;
    out_fine_nxt    = out_fine_r;
    out_locks_nxt   = out_locks_r;
    out_nm_nxt      = out_nm_r;
    div_req         = '0;

    case (state_r)
      S_IDLE: begin
        if (store_en) begin
          bank_nxt     = bank_new;
          low_bank_nxt = low_new;
          count_nxt    = count_r + 1'b1;
        end
        if (accept && in_last) begin
          reinit_nxt = in_reinit;
          csum_nxt   = '0;
          idx_nxt    = '0;
          state_nxt  = S_CSUM;
        end
      end
      // sum the stored coarse codes
      S_CSUM: begin
        if (idx_r == count_r) begin
          launched_nxt = 1'b0;
          state_nxt    = S_CDIV;
        end else begin
          csum_nxt = csum_r + CSUM_W'(rd_coarse);
          idx_nxt  = idx_r + 1'b1;
        end
      end
      // round the coarse sum over the batch size
      S_CDIV: begin
        cavg_nxt  = 8'(csum_rnd / CRND_W'(CAVG_DIV));
        fsum_nxt  = '0;
        match_nxt = '0;
        idx_nxt   = '0;
        state_nxt = S_FSUM;
      end
      // sum the fine words whose coarse matches the average
      S_FSUM: begin
        if (idx_r == count_r) begin
          launched_nxt = 1'b0;
          state_nxt    = S_FDIV;
        end else begin
          if (rd_coarse == cavg_r) begin
            fsum_nxt  = fsum_r + FSUM_W'(rd_fine);
            match_nxt = match_r + 1'b1;
          end
          idx_nxt = idx_r + 1'b1;
        end
      end
      // rounded fine average, zero when nothing matched
      S_FDIV: begin
        if (match_r == '0) begin
          favg_nxt  = '0;
          state_nxt = S_BLEND;
        end else begin
          div_req.start    = !launched_r;
          div_req.dividend = DIV_NUM_W'({fsum_r, 1'b0}) + DIV_NUM_W'(match_r);
          div_req.divisor  = DIV_DEN_W'({match_r, 1'b0});
          launched_nxt     = 1'b1;
          if (div_rsp.done && launched_r) begin
            favg_nxt  = div_rsp.quotient[15:0];
            state_nxt = S_BLEND;
          end
        end
      end
      // take the new average or form the weighted numerator
      S_BLEND: begin
        if (reinit_r || (cavg_r != prev_coarse_r)) begin
          fine_res_nxt = favg_r;
          state_nxt    = S_DONE;
        end else begin
          num_nxt      = BLEND_W'(prev_fine_r) * BLEND_W'(weight_r) + BLEND_W'(favg_r);
          launched_nxt = 1'b0;
          state_nxt    = S_BDIV;
        end
      end
      // rounded blend over the total weight
      S_BDIV: begin
        div_req.start    = !launched_r;
        div_req.dividend = DIV_NUM_W'({num_r, 1'b0}) + DIV_NUM_W'(weight_p1);
        div_req.divisor  = DIV_DEN_W'({weight_p1, 1'b0});
        launched_nxt     = 1'b1;
        if (div_rsp.done && launched_r) begin
          fine_res_nxt = div_rsp.quotient[15:0];
          state_nxt    = S_DONE;
        end
      end
      // hand over the result once the output register is free
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_cavg_nxt    = cavg_r;
          out_fine_nxt    = fine_res_r;
          out_locks_nxt   = 4'(count_r);
          out_nm_nxt      = (match_r == '0);
          prev_coarse_nxt = cavg_r;
          prev_fine_nxt   = fine_res_r;
          count_nxt       = '0;
          bank_nxt        = '0;
          low_bank_nxt    = '0;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state and history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      count_r       <= '0;
      bank_r        <= '0;
      low_bank_r    <= '0;
      prev_coarse_r <= '0;
      prev_fine_r   <= '0;
      weight_r      <= 8'd1;
      launched_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      count_r       <= count_nxt;
      bank_r        <= bank_nxt;
      low_bank_r    <= low_bank_nxt;
      prev_coarse_r <= prev_coarse_nxt;
      prev_fine_r   <= prev_fine_nxt;
      weight_r      <= weight_nxt;
      launched_r    <= launched_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    match_r     <= match_nxt;
    reinit_r    <= reinit_nxt;
    csum_r      <= csum_nxt;
    fsum_r      <= fsum_nxt;
    cavg_r      <= cavg_nxt;
    favg_r      <= favg_nxt;
    fine_res_r  <= fine_res_nxt;
    num_r       <= num_nxt;
    out_cavg_r  <= out_cavg_nxt;
    out_fine_r  <= out_fine_nxt;
    out_locks_r <= out_locks_nxt;
    out_nm_r    <= out_nm_nxt;
  end

  // batch store write
  always_ff @(posedge clk) begin
    if (store_en) begin
      coarse_store_r[count_r[IDX_W-1:0]] <= in_coarse_code;
      fine_store_r[count_r[IDX_W-1:0]]   <= {in_fine_top_byte, bank_new, low_new};
    end
  end

  dlaf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_valid          = out_valid_r;
  assign out_coarse_average = out_cavg_r;
  assign out_fine_smoothed  = out_fine_r;
  assign out_locks_taken    = out_locks_r;
  assign out_no_match       = out_nm_r;

endmodule

`default_nettype wire

FILE: design/dlaf_div.sv
`default_nettype none

module dlaf_div
  import dlaf_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire dlaf_div_req_t req,
  output dlaf_div_rsp_t      rsp
);

  logic [DIV_NUM_W-1:0] quot_r, quot_nxt;
  logic [DIV_DEN_W-1:0] den_r, den_nxt;
  logic [DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_DEN_W:0]   rem_sh;
  logic [DIV_DEN_W:0]   trial;

  // one quotient bit per cycle, restoring
  assign rem_sh = {rem_r, quot_r[DIV_NUM_W-1]};
  assign trial  = rem_sh - {1'b0, den_r};

  always_comb begin
    quot_nxt = quot_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      quot_nxt = req.dividend;
      den_nxt  = req.divisor;
      rem_nxt  = '0;
      cnt_nxt  = DIV_CNT_W'(DIV_NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[DIV_DEN_W]) begin
        rem_nxt  = trial[DIV_DEN_W-1:0];
        quot_nxt = {quot_r[DIV_NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh[DIV_DEN_W-1:0];
        quot_nxt = {quot_r[DIV_NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    quot_r <= quot_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quot_r;

endmodule

`default_nettype wire
